>>> hw/rtl/eik2n_pkg.sv
// shared types, widths and codes for the two-neighbour eikonal update
`default_nettype none
package eik2n_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int COST_WIDTH  = VALUE_WIDTH - 1;
	// |px - pz| and its square
	localparam int DIFF_W      = VALUE_WIDTH + 1;
	localparam int D2_W        = 2 * DIFF_W;
	// cx^2, cz^2, cx*cz and their sum
	localparam int PROD_W      = 2 * COST_WIDTH;
	localparam int DEN_W       = PROD_W + 1;
	// square root of the reduced discriminant
	localparam int SQ_W        = COST_WIDTH + 1;
	localparam int CZAD_W      = COST_WIDTH + DIFF_W;
	localparam int QSPLIT      = CZAD_W / 2;
	localparam int PSPLIT      = PROD_W / 2;
	localparam int Q_W         = COST_WIDTH + CZAD_W;
	localparam int P_W         = PROD_W + SQ_W;
	localparam int MAG_W       = Q_W + 1;
	// the root offset from pz stays below 2^(VALUE_WIDTH+2)
	localparam int QUO_W       = VALUE_WIDTH + 3;
	localparam int RT_W        = QUO_W + 2;

	typedef enum logic [1:0] {
		METHOD_X    = 2'd0,
		METHOD_Z    = 2'd1,
		METHOD_QUAD = 2'd2,
		METHOD_NONE = 2'd3
	} method_t;

	typedef struct packed {
		logic [COST_WIDTH-1:0]         cost_x;
		logic [COST_WIDTH-1:0]         cost_z;
		logic signed [VALUE_WIDTH-1:0] potential_x;
		logic signed [VALUE_WIDTH-1:0] potential_z;
		logic                          has_x;
		logic                          has_z;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] new_potential;
		method_t                       method;
		logic                          valid_res;
	} out_item_t;

	// carried alongside the square root
	typedef struct packed {
		logic [DEN_W-1:0]  den;
		logic [Q_W-1:0]    q;
		logic [PROD_W-1:0] cxcz;
		logic              neg_d;
		logic              bad;
		in_item_t          base;
	} sq_side_t;

	// carried alongside the divider
	typedef struct packed {
		logic     neg;
		logic     bad;
		in_item_t base;
	} dv_side_t;

endpackage
`default_nettype wire

>>> hw/rtl/eik2n_top.sv
// two-neighbour upwind eikonal update, fully pipelined
//
//  channel   dir   handshake                     payload
//  item      in    item_valid / item_ready       in_item_t (costs, potentials, flags)
//  result    out   result_valid / result_ready   out_item_t (potential, method, flag)
//
//  one item per cycle while the skid entry is free; the square root and divider
//  pipelines produce one result bit per stage.
//  reset clears every stage valid bit and both result buffer entries.
//  a result that is not taken fills the skid entry, then the whole pipeline holds;
//  while only the output register waits, the pipeline and the input keep moving.
`default_nettype none
module eikonal_two_neighbour_update_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire eik2n_pkg::in_item_t item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output eik2n_pkg::out_item_t     result
);
	import eik2n_pkg::*;

	localparam int W = VALUE_WIDTH;
	localparam int SQ_SIDE_W = $bits(sq_side_t);
	localparam int DV_SIDE_W = $bits(dv_side_t);

	logic en;

	// stage 1: input register
	logic     v_s1;
	in_item_t item_s1;

	// stage 2: first products
	logic                   v_s2;
	in_item_t               base_s2;
	logic [PROD_W-1:0]      x2_s2;
	logic [PROD_W-1:0]      z2_s2;
	logic [PROD_W-1:0]      cxcz_s2;
	logic [D2_W-1:0]        d2_s2;
	logic [CZAD_W-1:0]      czad_s2;
	logic                   negd_s2;
	logic signed [DIFF_W-1:0] d_c;
	logic [DIFF_W-1:0]      ad_c;

	// stage 3: sum of squares and split product for cz^2*|d|
	logic                   v_s3;
	in_item_t               base_s3;
	logic [DEN_W-1:0]       den_s3;
	logic [D2_W-1:0]        d2_s3;
	logic [COST_WIDTH+QSPLIT-1:0]        qlo_s3;
	logic [COST_WIDTH+CZAD_W-QSPLIT-1:0] qhi_s3;
	logic [PROD_W-1:0]      cxcz_s3;
	logic                   negd_s3;
	logic                   bothnz_s3;

	// stage 4: discriminant check and radicand
	logic                   v_s4;
	logic [DEN_W-1:0]       rad_s4;
	sq_side_t               sq_s4;
	logic [D2_W-1:0]        den_ext_c;
	logic                   den_ge_c;

	// square root
	logic                   sq_v;
	logic [SQ_W-1:0]        sq_root;
	logic [SQ_SIDE_W-1:0]   sq_side_vec;
	sq_side_t               sq_out;

	// stage 5: split product cx*cz*s
	logic                   v_s5;
	sq_side_t               sq_s5;
	logic [PSPLIT+SQ_W-1:0]        plo_s5;
	logic [PROD_W-PSPLIT+SQ_W-1:0] phi_s5;

	// stage 6: p assembled, q carried alongside
	logic                   v_s6;
	logic [P_W-1:0]         p_s6;
	sq_side_t               sq_s6;

	// stage 7: signed numerator magnitude
	logic                   v_s7;
	logic [MAG_W-1:0]       mag_s7;
	logic [DEN_W-1:0]       den_s7;
	dv_side_t               dv_s7;
	logic [MAG_W-1:0]       p_ext_c;
	logic [MAG_W-1:0]       q_ext_c;

	// divider
	logic                   dv_v;
	logic [QUO_W-1:0]       dv_quo;
	logic                   dv_rem_nz;
	logic [DV_SIDE_W-1:0]   dv_side_vec;
	dv_side_t               dv_out;

	// stage 8: root and fallback sums
	logic                   v_s8;
	in_item_t               base_s8;
	logic                   bad_s8;
	logic signed [RT_W-1:0] root_s8;
	logic signed [W:0]      fbx_s8;
	logic signed [W:0]      fbz_s8;
	logic signed [QUO_W:0]  quo_c;
	logic [QUO_W:0]         qm_ext_c;

	// final select and saturation
	logic                   quad_ok_c;
	logic                   use_x_c;
	logic signed [RT_W-1:0] u_c;
	logic signed [RT_W-1:0] px_ext_c;
	logic signed [RT_W-1:0] pz_ext_c;
	out_item_t              res_c;

	assign item_ready = en;

	// stage 1 -> 2 arithmetic
	always_comb begin
		d_c  = $signed({item_s1.potential_x[W-1], item_s1.potential_x})
		     - $signed({item_s1.potential_z[W-1], item_s1.potential_z});
		ad_c = d_c[DIFF_W-1] ? DIFF_W'(-d_c) : DIFF_W'(d_c);
	end

	// stage 3 -> 4
	always_comb begin
		den_ext_c = D2_W'(den_s3);
		den_ge_c  = den_ext_c >= d2_s3;
	end

	assign sq_out = sq_side_t'(sq_side_vec);

	// stage 6 -> 7
	always_comb begin
		p_ext_c = MAG_W'(p_s6);
		q_ext_c = MAG_W'(sq_s6.q);
	end

	assign dv_out = dv_side_t'(dv_side_vec);

	// stage 8 inputs: floor toward minus infinity on negative quotients
	always_comb begin
		qm_ext_c = {1'b0, dv_quo};
		quo_c    = dv_out.neg ? $signed(-qm_ext_c - (QUO_W+1)'(dv_rem_nz))
		                      : $signed(qm_ext_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= sq_v;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;

			base_s2 <= item_s1;
			x2_s2   <= PROD_W'(item_s1.cost_x) * PROD_W'(item_s1.cost_x);
			z2_s2   <= PROD_W'(item_s1.cost_z) * PROD_W'(item_s1.cost_z);
			cxcz_s2 <= PROD_W'(item_s1.cost_x) * PROD_W'(item_s1.cost_z);
			d2_s2   <= D2_W'(ad_c) * D2_W'(ad_c);
			czad_s2 <= CZAD_W'(item_s1.cost_z) * CZAD_W'(ad_c);
			negd_s2 <= d_c[DIFF_W-1];

			base_s3   <= base_s2;
			den_s3    <= DEN_W'(x2_s2) + DEN_W'(z2_s2);
			d2_s3     <= d2_s2;
			qlo_s3    <= (COST_WIDTH+QSPLIT)'(base_s2.cost_z)
			           * (COST_WIDTH+QSPLIT)'(czad_s2[QSPLIT-1:0]);
			qhi_s3    <= (COST_WIDTH+CZAD_W-QSPLIT)'(base_s2.cost_z)
			           * (COST_WIDTH+CZAD_W-QSPLIT)'(czad_s2[CZAD_W-1:QSPLIT]);
			cxcz_s3   <= cxcz_s2;
			negd_s3   <= negd_s2;
			bothnz_s3 <= (base_s2.cost_x != '0) && (base_s2.cost_z != '0);

			rad_s4     <= den_ge_c ? DEN_W'(den_ext_c - d2_s3) : '0;
			sq_s4.den  <= den_s3;
			sq_s4.q    <= (Q_W'(qhi_s3) << QSPLIT) + Q_W'(qlo_s3);
			sq_s4.cxcz <= cxcz_s3;
			sq_s4.neg_d <= negd_s3;
			// no root when a is zero, or when both costs are nonzero and the discriminant is negative
			sq_s4.bad  <= (den_s3 == '0) || (bothnz_s3 && !den_ge_c);
			sq_s4.base <= base_s3;

			sq_s5  <= sq_out;
			plo_s5 <= (PSPLIT+SQ_W)'(sq_out.cxcz[PSPLIT-1:0]) * (PSPLIT+SQ_W)'(sq_root);
			phi_s5 <= (PROD_W-PSPLIT+SQ_W)'(sq_out.cxcz[PROD_W-1:PSPLIT])
			        * (PROD_W-PSPLIT+SQ_W)'(sq_root);

			p_s6  <= (P_W'(phi_s5) << PSPLIT) + P_W'(plo_s5);
			sq_s6 <= sq_s5;

			den_s7       <= sq_s6.den;
			dv_s7.bad    <= sq_s6.bad;
			dv_s7.base   <= sq_s6.base;
			if (!sq_s6.neg_d) begin
				mag_s7    <= p_ext_c + q_ext_c;
				dv_s7.neg <= 1'b0;
			end else if (p_ext_c >= q_ext_c) begin
				mag_s7    <= p_ext_c - q_ext_c;
				dv_s7.neg <= 1'b0;
			end else begin
				mag_s7    <= q_ext_c - p_ext_c;
				dv_s7.neg <= 1'b1;
			end

			base_s8 <= dv_out.base;
			bad_s8  <= dv_out.bad;
			root_s8 <= RT_W'($signed(dv_out.base.potential_z)) + RT_W'(quo_c);
			fbx_s8  <= $signed({dv_out.base.potential_x[W-1], dv_out.base.potential_x})
			         + $signed({2'b00, dv_out.base.cost_x});
			fbz_s8  <= $signed({dv_out.base.potential_z[W-1], dv_out.base.potential_z})
			         + $signed({2'b00, dv_out.base.cost_z});
		end
	end

	eik2n_sqrt_pipe #(
		.SW     (SQ_W),
		.SIDE_W (SQ_SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s4),
		.rad      ((2*SQ_W)'(rad_s4)),
		.side_in  (sq_s4),
		.out_v    (sq_v),
		.root     (sq_root),
		.side_out (sq_side_vec)
	);

	eik2n_div_pipe #(
		.NUM_W  (MAG_W),
		.DEN_W  (DEN_W),
		.QW     (QUO_W),
		.SIDE_W (DV_SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s7),
		.num      (mag_s7),
		.den      (den_s7),
		.side_in  (dv_s7),
		.out_v    (dv_v),
		.quo      (dv_quo),
		.rem_nz   (dv_rem_nz),
		.side_out (dv_side_vec)
	);

	// choose quadratic root or single-side update, then saturate; with no neighbour the result is zero and flagged invalid
	always_comb begin
		px_ext_c  = RT_W'(base_s8.potential_x);
		pz_ext_c  = RT_W'(base_s8.potential_z);
		quad_ok_c = base_s8.has_x && base_s8.has_z && !bad_s8
		         && (root_s8 >= px_ext_c) && (root_s8 >= pz_ext_c);
		use_x_c   = base_s8.has_x
		         && (!base_s8.has_z || (base_s8.potential_x < base_s8.potential_z));
		res_c.valid_res = 1'b1;
		if (quad_ok_c) begin
			u_c          = root_s8;
			res_c.method = METHOD_QUAD;
		end else if (use_x_c) begin
			u_c          = RT_W'(fbx_s8);
			res_c.method = METHOD_X;
		end else begin
			u_c          = RT_W'(fbz_s8);
			res_c.method = METHOD_Z;
		end
		if (u_c[RT_W-1:W-1] == '0 || u_c[RT_W-1:W-1] == '1) begin
			res_c.new_potential = u_c[W-1:0];
		end else if (u_c[RT_W-1]) begin
			res_c.new_potential = {1'b1, {(W-1){1'b0}}};
		end else begin
			res_c.new_potential = {1'b0, {(W-1){1'b1}}};
		end
		if (!base_s8.has_x && !base_s8.has_z) begin
			res_c.new_potential = '0;
			res_c.method        = METHOD_NONE;
			res_c.valid_res     = 1'b0;
		end
	end

	eik2n_out_buf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.pipe_v       (v_s8),
		.pipe_item    (res_c),
		.en           (en),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("input held off with no result waiting");

	a_none_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.valid_res |-> result.method == METHOD_NONE)
		else $error("invalid result carries a method other than none");

	a_quad_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.method == METHOD_QUAD |-> result.valid_res)
		else $error("quadratic result flagged invalid");

endmodule
`default_nettype wire

>>> hw/rtl/eik2n_sqrt_pipe.sv
// pipelined restoring integer square root, one result bit per stage
`default_nettype none
module eik2n_sqrt_pipe #(
	parameter int SW     = eik2n_pkg::SQ_W,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire logic [2*SW-1:0]   rad,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_v,
	output logic [SW-1:0]          root,
	output logic [SIDE_W-1:0]      side_out
);

	logic              v_s    [1:SW];
	logic [SW-1:0]     root_s [1:SW];
	logic [SIDE_W-1:0] side_s [1:SW];
	logic [SW:0]       rem_s  [1:SW-1];
	logic [2*SW-1:0]   rad_s  [1:SW-1];

	for (genvar k = 0; k < SW; k++) begin : g_st
		logic [SW:0]       rem_c;
		logic [SW-1:0]     root_c;
		logic [2*SW-1:0]   rad_c;
		logic              v_c;
		logic [SIDE_W-1:0] side_c;
		logic [SW+1:0]     rem_n;
		logic [SW+1:0]     trial;
		logic [SW+1:0]     diff;
		logic              ge;

		if (k == 0) begin : g_in
			assign rem_c  = '0;
			assign root_c = '0;
			assign rad_c  = rad;
			assign v_c    = in_v;
			assign side_c = side_in;
		end else begin : g_mid
			assign rem_c  = rem_s[k];
			assign root_c = root_s[k];
			assign rad_c  = rad_s[k];
			assign v_c    = v_s[k];
			assign side_c = side_s[k];
		end

		// bring down the next two radicand bits
		assign rem_n = {rem_c[SW-1:0], rad_c[2*SW-1 -: 2]};
		assign trial = {root_c, 2'b01};
		assign ge    = rem_n >= trial;
		assign diff  = rem_n - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_c[SW-2:0], ge};
				side_s[k+1] <= side_c;
			end
		end

		if (k < SW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? diff[SW:0] : rem_n[SW:0];
					rad_s[k+1] <= rad_c << 2;
				end
			end
		end
	end

	assign out_v    = v_s[SW];
	assign root     = root_s[SW];
	assign side_out = side_s[SW];

endmodule
`default_nettype wire

>>> hw/rtl/eik2n_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, remainder flag at the end
`default_nettype none
module eik2n_div_pipe #(
	parameter int NUM_W  = eik2n_pkg::MAG_W,
	parameter int DEN_W  = eik2n_pkg::DEN_W,
	parameter int QW     = eik2n_pkg::QUO_W,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_v,
	output logic [QW-1:0]          quo,
	output logic                   rem_nz,
	output logic [SIDE_W-1:0]      side_out
);

	logic              v_s    [1:QW];
	logic [QW-1:0]     q_s    [1:QW];
	logic [DEN_W-1:0]  rem_s  [1:QW];
	logic [SIDE_W-1:0] side_s [1:QW];
	logic [QW-1:0]     low_s  [1:QW-1];
	logic [DEN_W-1:0]  den_s  [1:QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic [DEN_W-1:0]  rem_c;
		logic [QW-1:0]     low_c;
		logic [QW-1:0]     q_c;
		logic [DEN_W-1:0]  den_c;
		logic              v_c;
		logic [SIDE_W-1:0] side_c;
		logic [DEN_W:0]    rem_n;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_in
			// upper numerator bits are already below the divisor
			assign rem_c  = DEN_W'(num[NUM_W-1:QW]);
			assign low_c  = num[QW-1:0];
			assign q_c    = '0;
			assign den_c  = den;
			assign v_c    = in_v;
			assign side_c = side_in;
		end else begin : g_mid
			assign rem_c  = rem_s[k];
			assign low_c  = low_s[k];
			assign q_c    = q_s[k];
			assign den_c  = den_s[k];
			assign v_c    = v_s[k];
			assign side_c = side_s[k];
		end

		assign rem_n = {rem_c, low_c[QW-1]};
		assign ge    = rem_n >= {1'b0, den_c};
		assign diff  = rem_n - {1'b0, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : rem_n[DEN_W-1:0];
				q_s[k+1]    <= {q_c[QW-2:0], ge};
				side_s[k+1] <= side_c;
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[k+1] <= low_c << 1;
					den_s[k+1] <= den_c;
				end
			end
		end
	end

	assign out_v    = v_s[QW];
	assign quo      = q_s[QW];
	assign rem_nz   = |rem_s[QW];
	assign side_out = side_s[QW];

endmodule
`default_nettype wire

>>> hw/rtl/eik2n_out_buf.sv
// two-entry result buffer: output register plus skid register
`default_nettype none
module eik2n_out_buf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pipe_v,
	input  wire eik2n_pkg::out_item_t pipe_item,
	output logic                      en,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output eik2n_pkg::out_item_t      result
);
	import eik2n_pkg::*;

	logic      out_v_q;
	logic      skid_v_q;
	out_item_t out_q;
	out_item_t skid_q;
	logic      load_out;
	logic      load_skid;
	logic      from_skid;

	// pipeline moves only while the skid entry is free
	assign en = !skid_v_q;

	always_comb begin
		from_skid = skid_v_q && result_ready;
		load_out  = !skid_v_q && pipe_v && (!out_v_q || result_ready);
		load_skid = !skid_v_q && pipe_v && out_v_q && !result_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_out || from_skid) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
			if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (from_skid) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (from_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= pipe_item;
		end
		if (load_skid) begin
			skid_q <= pipe_item;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");

	a_skid_drains_first: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && result_ready |=> result == $past(skid_q))
		else $error("skid entry not passed on after output transfer");

endmodule
`default_nettype wire

>>> bench/eik2n_checker.sv
// watches both channels of the eikonal update, predicts each result and compares
`timescale 1ns / 1ps
module eik2n_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	input  wire logic                 item_ready,
	input  wire eik2n_pkg::in_item_t  item,
	input  wire logic                 result_valid,
	input  wire logic                 result_ready,
	input  wire eik2n_pkg::out_item_t result,
	output int                        fail_count,
	output int                        pending
);
	import eik2n_pkg::*;

	out_item_t cell_updates[$];

	assign pending = cell_updates.size();

	function automatic logic signed [VALUE_WIDTH-1:0] saturate(logic signed [127:0] v);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = (128'sd1 <<< (VALUE_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi[VALUE_WIDTH-1:0];
		end
		if (v < lo) begin
			return lo[VALUE_WIDTH-1:0];
		end
		return v[VALUE_WIDTH-1:0];
	endfunction

	function automatic logic [127:0] isqrt(logic [127:0] n);
		logic [127:0] r;
		logic [127:0] c;
		r = 0;
		for (int i = 62; i >= 0; i--) begin
			c = r | (128'd1 << i);
			if (c * c <= n) begin
				r = c;
			end
		end
		return r;
	endfunction

	function automatic out_item_t update_cell(in_item_t it);
		out_item_t o;
		logic signed [127:0] px, pz, cx, cz, d, ad, den, d2, p, q, mag, quo, u, root;
		logic ok;
		px = it.potential_x;
		pz = it.potential_z;
		cx = {1'b0, it.cost_x};
		cz = {1'b0, it.cost_z};
		o.valid_res = 1'b1;
		ok = 1'b0;
		if (!it.has_x && !it.has_z) begin
			o.new_potential = '0;
			o.method = METHOD_NONE;
			o.valid_res = 1'b0;
			return o;
		end
		if (it.has_x && it.has_z) begin
			den = cx * cx + cz * cz;
			d = px - pz;
			ad = d < 0 ? -d : d;
			d2 = ad * ad;
			p = 0;
			ok = den != 0;
			if (ok && cx != 0 && cz != 0) begin
				if (den < d2) begin
					ok = 1'b0;
				end else begin
					p = cx * cz * $signed(isqrt(den - d2));
				end
			end
			if (ok) begin
				q = cz * cz * ad;
				mag = d >= 0 ? p + q : p - q;
				// floor division, mag may be negative
				quo = mag / den;
				if (mag < 0 && quo * den != mag) begin
					quo = quo - 1;
				end
				root = pz + quo;
				ok = root >= px && root >= pz;
				u = root;
			end
		end
		if (ok) begin
			o.method = METHOD_QUAD;
		end else if (it.has_x && (!it.has_z || px < pz)) begin
			u = px + cx;
			o.method = METHOD_X;
		end else begin
			u = pz + cz;
			o.method = METHOD_Z;
		end
		o.new_potential = saturate(u);
		return o;
	endfunction

	initial fail_count = 0;

	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				cell_updates.insert(cell_updates.size(), update_cell(item));
			end
			if (result_valid && result_ready) begin
				if (cell_updates.size() == 0) begin
					$error("unexpected result transfer");
					fail_count++;
				end else begin
					exp_r = cell_updates.pop_front();
					if (result.new_potential !== exp_r.new_potential) begin
						$error("new_potential exp %0d got %0d", exp_r.new_potential,
							result.new_potential);
						fail_count++;
					end
					if (result.method !== exp_r.method) begin
						$error("method exp %0d got %0d", exp_r.method, result.method);
						fail_count++;
					end
					if (result.valid_res !== exp_r.valid_res) begin
						$error("valid_res exp %0d got %0d", exp_r.valid_res,
							result.valid_res);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

>>> bench/eikonal_two_neighbour_update_top_tb.sv
// stimulus and verdict for the two-neighbour eikonal update
`timescale 1ns / 1ps
module eikonal_two_neighbour_update_top_tb;
	import eik2n_pkg::*;

	localparam int LATENCY = 2 * VALUE_WIDTH + 12;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;
	int        fail_count;
	int        pending;
	logic      inputs_done = 1'b0;

	always #4 clk = ~clk;

	eikonal_two_neighbour_update_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	eik2n_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0;
	endfunction

	function automatic logic [COST_WIDTH-1:0] rand_cost();
		unique case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return COST_WIDTH'($urandom_range(0, 32'h0008_0000));
			default: return COST_WIDTH'($urandom);
		endcase
	endfunction

	// valid drops only when a gap follows, so back-to-back items keep it high
	task automatic send(in_item_t it);
		int gap;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		gap = gap_len();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random();
		in_item_t it;
		logic signed [31:0] base;
		it.cost_x = rand_cost();
		it.cost_z = rand_cost();
		it.has_x = $urandom_range(0, 7) != 0;
		it.has_z = $urandom_range(0, 7) != 0;
		if ($urandom_range(0, 3) == 0) begin
			it.potential_x = $urandom;
			it.potential_z = $urandom;
		end else begin
			// nearby potentials so the quadratic root is accepted often
			base = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			it.cost_x = COST_WIDTH'($urandom_range(1, 32'h0004_0000));
			it.cost_z = COST_WIDTH'($urandom_range(1, 32'h0004_0000));
			it.potential_x = base + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			it.potential_z = base;
		end
		send(it);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 19) == 0) begin
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			result_ready <= 1'b1;
		end else if (!result_ready) begin
			result_ready <= $urandom_range(0, 2) != 0;
		end
	end

	initial begin
		in_item_t it;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		it = '{cost_x: 31'h7fffffff, cost_z: 31'h7fffffff,
			potential_x: 32'h7fffffff, potential_z: 32'h7fffffff, has_x: 1'b1, has_z: 1'b1};
		send(it);
		it = '{31'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h80000000, 1'b1, 1'b1};
		send(it);
		it = '{31'h7fffffff, 31'h0, 32'h7fffffff, 32'h0, 1'b1, 1'b0};
		send(it);
		it = '{31'h0, 31'h7fffffff, 32'h0, 32'h7fffffff, 1'b0, 1'b1};
		send(it);
		it = '{31'h12345, 31'h6789, 32'h1000, 32'h2000, 1'b0, 1'b0};
		send(it);
		it = '{31'h0, 31'h0, 32'h10000, 32'h20000, 1'b1, 1'b1};
		send(it);
		it = '{31'h0, 31'h0, 32'h20000, 32'h20000, 1'b1, 1'b1};
		send(it);
		it = '{31'h10000, 31'h0, 32'h30000, 32'h50000, 1'b1, 1'b1};
		send(it);
		it = '{31'h0, 31'h10000, 32'h30000, 32'h50000, 1'b1, 1'b1};
		send(it);
		it = '{31'h10000, 31'h10000, 32'h10000, 32'h10000, 1'b1, 1'b1};
		send(it);
		it = '{31'h10000, 31'h10000, 32'h10000, 32'h90000, 1'b1, 1'b1};
		send(it);
		it = '{31'h10000, 31'h10000, 32'h90000, 32'h10000, 1'b1, 1'b1};
		send(it);
		it = '{31'h30000, 31'h40000, 32'hffff0000, 32'h8000, 1'b1, 1'b1};
		send(it);
		it = '{31'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1, 1'b1};
		send(it);
		it = '{31'h7fffffff, 31'h1, 32'h7fffffff, 32'h80000000, 1'b1, 1'b1};
		send(it);
		it = '{31'h55555555, 31'h2aaaaaaa, 32'haaaaaaaa, 32'h55555555, 1'b1, 1'b1};
		send(it);
		for (int n = 0; n < 500; n++) begin
			send_random();
			if (n == 250) begin
				// hold off until the pipeline has emptied
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		item_valid <= 1'b0;
		inputs_done <= 1'b1;
	end

	initial begin
		wait (inputs_done);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end
endmodule
